### design/dbc_pkg.sv
// Shared types, constants and the per-button update function of the debouncer.
// No dependencies; every other design file imports this package.
package dbc_pkg;

   localparam int NUM_BUTTONS = 8;
   localparam int LANES = 8;
   localparam int MEM_DEPTH = (NUM_BUTTONS < LANES) ? NUM_BUTTONS : LANES;
   localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int LANE_W = $clog2(LANES);
   localparam int ACT_W = $clog2(LANES + 1);
   localparam int ENABLED_W = 4;
   localparam int MASK_W = 8;
   localparam int RUN_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [RUN_W-1:0] THRESHOLD_AT_RESET = RUN_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLED_BUTTONS  = 2'd0,
      CSR_ACTIVE_LOW_MASK  = 2'd1,
      CSR_STABLE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             target;
      logic [RUN_W-1:0] run;
      logic             confirmed;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{target: 1'b0, run: THRESHOLD_AT_RESET,
                                         confirmed: 1'b0};

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } mem_wr_type;

   typedef struct packed {
      entry_type entry;
      logic      press;
      logic      release_ev;
   } upd_type;

   typedef struct packed {
      logic [MASK_W-1:0] press;
      logic [MASK_W-1:0] release_ev;
      logic [MASK_W-1:0] confirmed;
   } rsp_type;

   function automatic upd_type dbc_step(entry_type e, logic logical, logic [RUN_W-1:0] thr);
      upd_type          u;
      logic [RUN_W-1:0] run_inc;
      u = '{entry: e, press: 1'b0, release_ev: 1'b0};
      run_inc = e.run + RUN_W'(1);
      if (logical == e.target) begin
         if (e.run < thr) begin
            u.entry.run = run_inc;
            if (run_inc >= thr && logical != e.confirmed) begin
               u.entry.confirmed = logical;
               u.press = logical;
               u.release_ev = ~logical;
            end
         end
      end else begin
         u.entry.target = logical;
         u.entry.run = '0;
      end
      return u;
   endfunction

endpackage

### design/dbc_state_mem.sv
// Per-button state memory: registered synchronous read, one write port.
// Reset-valued entries via valid bits, write-to-read forwarding. Uses dbc_pkg.
module dbc_state_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [dbc_pkg::ADDR_W-1:0] rd_addr,
   input  dbc_pkg::mem_wr_type       wr,
   output dbc_pkg::entry_type        rd_data
);
   import dbc_pkg::*;

   entry_type              mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]   valid_ff;
   entry_type              rd_q_ff;
   entry_type              fwd_data_ff;
   logic                   rd_valid_ff;
   logic                   fwd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_q_ff <= mem_ff[rd_addr];
      fwd_data_ff <= wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
         fwd_ff <= wr.en && (wr.addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (rd_valid_ff ? rd_q_ff : ENTRY_RESET);

endmodule

### design/dbc_rsp_queue.sv
// Small result queue that decouples the update pipeline from the result channel.
// Uses dbc_pkg for the result type and depth.
module dbc_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dbc_pkg::rsp_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output dbc_pkg::rsp_type pop_data
);
   import dbc_pkg::*;

   rsp_type                slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wptr_ff;
   logic [RSP_PTR_W-1:0]   rptr_ff;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic                   pop;

   assign pop_valid = (count_ff != '0);
   assign pop = pop_valid && pop_ready;
   assign pop_data = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + RSP_PTR_W'(1);
         end
         count_ff <= count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != RSP_CNT_W'(RSP_DEPTH)) || pop)
      else $error("result queue written while full");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue count out of range");

   a_pop_moves_ptr: assert property (@(posedge clock) disable iff (reset)
      pop |=> rptr_ff == $past(rptr_ff) + RSP_PTR_W'(1))
      else $error("read pointer did not advance on pop");

endmodule

### design/multi_button_counter_debouncer_top.sv
// Each accepted input item makes one read-modify-write of the per-button state memory per
// enabled button (at most 8); a new item can be accepted during the last one of the previous
// item, unless four items are already in flight or waiting in the result queue; up to four
// results are buffered.
// Reset clears the block at once: all buttons released with a full run count, registers
// at their reset values; no clearing pass is needed. Uses dbc_pkg, dbc_state_mem, dbc_rsp_queue.
module multi_button_counter_debouncer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_raw_levels,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_press_events,
   output logic [7:0]                     rsp_release_events,
   output logic [7:0]                     rsp_confirmed_pressed,
   input  logic                           csr_wr_en,
   input  logic [dbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dbc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dbc_pkg::*;

   logic [ENABLED_W-1:0] enabled_ff;
   logic [MASK_W-1:0]    active_low_ff;
   logic [RUN_W-1:0]     threshold_ff;

   logic                 busy_ff;
   logic                 busy_in;
   logic [ADDR_W-1:0]    idx_ff;
   logic [ADDR_W-1:0]    idx_in;
   logic                 first_ff;
   logic                 first_in;
   logic [MASK_W-1:0]    raw_ff;
   logic [MASK_W-1:0]    raw_in;

   logic                 s1_valid_ff;
   logic                 s1_en_ff;
   logic                 s1_first_ff;
   logic                 s1_last_ff;
   logic                 s1_logical_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;

   rsp_type              acc_ff;
   rsp_type              acc_in;
   logic [RSP_CNT_W-1:0] occ_ff;

   logic [ACT_W-1:0]     n_active;
   logic [RUN_W-1:0]     thr;
   logic                 last_slot;
   logic                 req_fire;
   logic                 rsp_fire;
   logic [LANE_W-1:0]    issue_lane;
   logic [LANE_W-1:0]    s1_lane;
   entry_type            rd_entry;
   upd_type              upd;
   mem_wr_type           mem_wr;
   rsp_type              rsp_data;
   logic                 push;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= '0;
         active_low_ff <= '0;
         threshold_ff <= THRESHOLD_AT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLED_BUTTONS:  enabled_ff <= csr_wdata[ENABLED_W-1:0];
            CSR_ACTIVE_LOW_MASK:  active_low_ff <= csr_wdata[MASK_W-1:0];
            CSR_STABLE_THRESHOLD: threshold_ff <= csr_wdata[RUN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (ACT_W'(enabled_ff) > ACT_W'(MEM_DEPTH)) begin
         n_active = ACT_W'(MEM_DEPTH);
      end else begin
         n_active = ACT_W'(enabled_ff);
      end
      thr = (threshold_ff == '0) ? RUN_W'(1) : threshold_ff;
   end

   assign last_slot = (n_active == '0) || ((ACT_W'(idx_ff) + ACT_W'(1)) == n_active);
   assign req_ready = (occ_ff < RSP_CNT_W'(RSP_DEPTH)) && (!busy_ff || last_slot);
   assign req_fire = req_valid && req_ready;
   assign issue_lane = LANE_W'(idx_ff);

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      first_in = 1'b0;
      raw_in = raw_ff;
      if (busy_ff && !last_slot) begin
         idx_in = idx_ff + ADDR_W'(1);
      end else begin
         busy_in = req_fire;
         idx_in = '0;
         if (req_fire) begin
            first_in = 1'b1;
            raw_in = req_raw_levels;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         first_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s1_en_ff <= 1'b0;
         occ_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         first_ff <= first_in;
         s1_valid_ff <= busy_ff;
         s1_en_ff <= busy_ff && (n_active != '0);
         occ_ff <= occ_ff + RSP_CNT_W'(req_fire) - RSP_CNT_W'(rsp_fire);
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
      s1_first_ff <= first_ff;
      s1_last_ff <= last_slot;
      s1_addr_ff <= idx_ff;
      s1_logical_ff <= raw_ff[issue_lane] ^ active_low_ff[issue_lane];
      acc_ff <= acc_in;
   end

   dbc_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (idx_ff),
      .wr      (mem_wr),
      .rd_data (rd_entry)
   );

   assign s1_lane = LANE_W'(s1_addr_ff);

   always_comb begin
      upd = dbc_step(rd_entry, s1_logical_ff, thr);
      mem_wr.en = s1_valid_ff && s1_en_ff;
      mem_wr.addr = s1_addr_ff;
      mem_wr.data = upd.entry;
      acc_in = s1_first_ff ? '0 : acc_ff;
      if (s1_valid_ff && s1_en_ff) begin
         acc_in.press[s1_lane] = upd.press;
         acc_in.release_ev[s1_lane] = upd.release_ev;
         acc_in.confirmed[s1_lane] = upd.entry.confirmed;
      end
      if (!s1_valid_ff) begin
         acc_in = acc_ff;
      end
   end

   assign push = s1_valid_ff && s1_last_ff;

   dbc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (acc_in),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (rsp_data)
   );

   assign rsp_fire = rsp_valid && rsp_ready;
   assign rsp_press_events = rsp_data.press;
   assign rsp_release_events = rsp_data.release_ev;
   assign rsp_confirmed_pressed = rsp_data.confirmed;

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("more items in flight than result slots");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != '0)
      else $error("result offered with no item outstanding");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> ACT_W'(mem_wr.addr) < n_active)
      else $error("state written for a disabled button");

   a_issue_feeds_stage: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> s1_valid_ff)
      else $error("issued slot did not reach the update stage");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_button_counter_debouncer_top: a debounce tracker class
// predicts every report from the accepted sample ticks and register writes.
// Depends on dbc_pkg and the design's top module.
module tb;
   import dbc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   class debounce_tracker;
      logic                 target_lvl [NUM_BUTTONS];
      logic [RUN_W-1:0]     run_len [NUM_BUTTONS];
      logic                 confirmed [NUM_BUTTONS];
      logic [ENABLED_W-1:0] enabled;
      logic [MASK_W-1:0]    low_mask;
      logic [RUN_W-1:0]     threshold;
      rsp_type              expected_reports [$];
      int unsigned          failures, ticks, reports_seen, presses, releases;

      function new();
         enabled = '0;
         low_mask = '0;
         threshold = THRESHOLD_AT_RESET;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            target_lvl[b] = 1'b0;
            run_len[b] = THRESHOLD_AT_RESET;
            confirmed[b] = 1'b0;
         end
         failures = 0;
         ticks = 0;
         reports_seen = 0;
         presses = 0;
         releases = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ENABLED_BUTTONS: enabled = value[ENABLED_W-1:0];
            CSR_ACTIVE_LOW_MASK: low_mask = value[MASK_W-1:0];
            CSR_STABLE_THRESHOLD: threshold = value[RUN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(logic [7:0] raw);
         int unsigned      n;
         logic [RUN_W-1:0] thr;
         logic             lv;
         rsp_type          exp;
         n = (enabled > LANES) ? LANES : enabled;
         if (n > NUM_BUTTONS) n = NUM_BUTTONS;
         thr = (threshold == '0) ? RUN_W'(1) : threshold;
         exp = '0;
         for (int b = 0; b < n; b++) begin
            lv = raw[b] ^ low_mask[b];
            if (lv == target_lvl[b]) begin
               if (run_len[b] < thr) begin
                  run_len[b] = run_len[b] + RUN_W'(1);
                  if (run_len[b] >= thr && lv != confirmed[b]) begin
                     confirmed[b] = lv;
                     if (lv) exp.press[b] = 1'b1;
                     else exp.release_ev[b] = 1'b1;
                  end
               end
            end else begin
               target_lvl[b] = lv;
               run_len[b] = '0;
            end
            exp.confirmed[b] = confirmed[b];
         end
         expected_reports.push_back(exp);
         ticks++;
      endfunction

      function void check_report(rsp_type got);
         rsp_type exp;
         if (expected_reports.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: report with no item pending: press %h release %h confirmed %h",
                        $realtime, got.press, got.release_ev, got.confirmed);
            return;
         end
         exp = expected_reports.pop_front();
         reports_seen++;
         presses += $countones(got.press);
         releases += $countones(got.release_ev);
         if (got !== exp) begin
            failures++;
            if (failures <= 10)
               $display("%0t: report %0d expected press %h release %h confirmed %h, got %h %h %h",
                        $realtime, reports_seen, exp.press, exp.release_ev, exp.confirmed,
                        got.press, got.release_ev, got.confirmed);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_raw_levels = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_press_events;
   logic [7:0]            rsp_release_events;
   logic [7:0]            rsp_confirmed_pressed;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   debounce_tracker tracker = new();
   logic            steady = 1'b0;
   logic [7:0]      held_levels = '0;
   int unsigned     bounce_left [8];
   int unsigned     settings_used = 0;

   multi_button_counter_debouncer_top DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_raw_levels        (req_raw_levels),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_press_events      (rsp_press_events),
      .rsp_release_events    (rsp_release_events),
      .rsp_confirmed_pressed (rsp_confirmed_pressed),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 16);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_report({rsp_press_events, rsp_release_events, rsp_confirmed_pressed});
   end

   task automatic send_tick(input logic [7:0] raw);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_levels <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_tick(raw);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(idx, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input logic [7:0] en, input logic [7:0] mask, input logic [7:0] thr);
      wait_for_results();
      write_reg(CSR_ENABLED_BUTTONS, en);
      write_reg(CSR_ACTIVE_LOW_MASK, mask);
      write_reg(CSR_STABLE_THRESHOLD, thr);
      settings_used++;
   endtask

   // Buttons hold a level for a random run, bounce briefly after each change,
   // and now and then the whole sample is noise.
   function automatic logic [7:0] next_raw(input int unsigned span);
      logic [7:0] raw;
      if ($urandom_range(0, 9 + 4 * span) == 0) return 8'($urandom);
      for (int b = 0; b < 8; b++) begin
         if ($urandom_range(0, span + 1) == 0) begin
            held_levels[b] = ~held_levels[b];
            bounce_left[b] = $urandom_range(0, 3);
         end
         raw[b] = held_levels[b];
         if (bounce_left[b] > 0) begin
            raw[b] = 1'($urandom_range(0, 1));
            bounce_left[b]--;
         end
      end
      return raw;
   endfunction

   task automatic run_random(input int unsigned count, input int unsigned span);
      for (int unsigned k = 0; k < count; k++) send_tick(next_raw(span));
   endtask

   initial begin
      int unsigned phase;
      logic [7:0]  en, mask, thr;
      int unsigned span;
      for (int b = 0; b < 8; b++) bounce_left[b] = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_tick(8'hFF);
      send_tick(8'h00);

      configure(8'd8, 8'h00, 8'd2);
      send_tick(8'hFF);
      send_tick(8'hFF);
      send_tick(8'hFF);
      send_tick(8'h00);
      send_tick(8'h00);
      send_tick(8'h00);

      configure(8'd15, 8'hFF, 8'd0);
      send_tick(8'hFF);
      send_tick(8'h00);
      send_tick(8'h00);
      send_tick(8'hA5);

      configure(8'd3, 8'h5A, 8'd255);
      write_reg(CSR_UNUSED_INDEX, 8'hFF);
      send_tick(8'h5A);
      send_tick(8'h0F);

      configure(8'd1, 8'h00, 8'd1);
      send_tick(8'h00);
      send_tick(8'h01);
      send_tick(8'h01);

      configure(8'd8, 8'h0F, 8'd6);
      repeat (4) send_tick(8'h00);
      configure(8'd8, 8'h0F, 8'd2);
      repeat (2) send_tick(8'h00);

      phase = 0;
      while (tracker.ticks < 1480) begin
         en = ($urandom_range(0, 9) < 7) ? 8'd8 : 8'($urandom);
         mask = 8'($urandom);
         case ($urandom_range(0, 9))
            0: thr = 8'd0;
            1: thr = 8'd255;
            2: thr = 8'($urandom_range(1, 255));
            default: thr = 8'($urandom_range(1, 6));
         endcase
         span = (thr == 0) ? 1 : thr;
         configure(en, mask, thr);
         steady = (phase == 2);
         if (phase == 4) begin
            run_random(60, span);
            wait_for_results();
            run_random(60, span);
         end else begin
            run_random($urandom_range(60, 200), span);
         end
         steady = 1'b0;
         phase++;
      end

      configure(8'd8, 8'($urandom), 8'd255);
      run_random(520, 255);

      wait_for_results();
      repeat (20) @(posedge clock);
      if (tracker.expected_reports.size() != 0) tracker.failures++;
      $display("Ran %0d sample ticks under %0d register settings.", tracker.ticks, settings_used);
      $display("Checked %0d reports carrying %0d press and %0d release events.",
               tracker.reports_seen, tracker.presses, tracker.releases);
      if (tracker.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d failing reports.", tracker.failures);
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Timed out waiting for the block.");
      $display("Mismatches found");
      $finish;
   end

endmodule
